### sv/zobrist_transposition_table_assert.svh
// assertion macros shared by the checker
`ifndef ZOBRIST_TRANSPOSITION_TABLE_ASSERT_SVH
`define ZOBRIST_TRANSPOSITION_TABLE_ASSERT_SVH

// same-cycle implication, idle during reset
`define ZTT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define ZTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define ZTT_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ztt_pkg.sv
package ztt_pkg;

    localparam int TABLE_ENTRIES = 65536;
    localparam int BOARD_SQUARES = 64;
    localparam int PIECE_KINDS   = 12;

    localparam int KEY_WORDS = BOARD_SQUARES * PIECE_KINDS;
    localparam int KEY_AW    = $clog2(KEY_WORDS);
    localparam int TBL_AW    = $clog2(TABLE_ENTRIES);

    localparam int OP_W    = 2;
    localparam int SQ_W    = 6;
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 4;
    localparam int HASH_W  = 64;
    localparam int DEPTH_W = 8;
    localparam int EVAL_W  = 16;
    localparam int ENTRY_W = HASH_W + DEPTH_W + EVAL_W;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 88;

    typedef enum logic [OP_W-1:0] {
        OP_KEY_LOAD = 2'd0,
        OP_QUERY    = 2'd1,
        OP_STORE    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_KEY,
        S_TBL
    } t_state;

    typedef struct packed {
        logic [HASH_W-1:0]  tag;
        logic [DEPTH_W-1:0] depth;
        logic [EVAL_W-1:0]  eval;
    } t_entry;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
    } t_kind;

    function automatic t_kind kind_of(input logic [CHAR_W-1:0] c);
        t_kind k;
        k.valid = 1'b1;
        k.kind  = '0;
        case (c)
            "p": k.kind = 4'd0;
            "r": k.kind = 4'd1;
            "n": k.kind = 4'd2;
            "b": k.kind = 4'd3;
            "q": k.kind = 4'd4;
            "k": k.kind = 4'd5;
            "P": k.kind = 4'd6;
            "R": k.kind = 4'd7;
            "N": k.kind = 4'd8;
            "B": k.kind = 4'd9;
            "Q": k.kind = 4'd10;
            "K": k.kind = 4'd11;
            default: k.valid = 1'b0;
        endcase
        if (int'(k.kind) >= PIECE_KINDS) begin
            k.valid = 1'b0;
        end
        return k;
    endfunction

endpackage

### sv/ztt_ram.sv
module ztt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/zobrist_transposition_table.sv
// key load: written on acceptance, no wait. board square: bounded by the key store's registered read.
// last square: an entry table read follows, then the result (queries) sits in the
// output register; a pending result stalls a later final query square only.
// reset (synchronous, active low) clears the hash and output valid, then sweeps the entry table
// to zeros at one entry per cycle, all 65536 entries with tready low; key store is not cleared.
module zobrist_transposition_table
    import ztt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // square, piece_char, key_piece, key_value, depth, eval, zero fill
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // operation
    input  logic [OP_W-1:0]      i_s_tuser,
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // entry_depth, entry_eval, entry_hash
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // found
    output logic [0:0]           o_m_tuser
);

    logic [SQ_W-1:0]    in_sq;
    logic [CHAR_W-1:0]  in_char;
    logic [KIND_W-1:0]  in_kp;
    logic [HASH_W-1:0]  in_kv;
    logic [DEPTH_W-1:0] in_depth;
    logic [EVAL_W-1:0]  in_eval;

    assign in_sq    = i_s_tdata[5:0];
    assign in_char  = i_s_tdata[13:6];
    assign in_kp    = i_s_tdata[17:14];
    assign in_kv    = i_s_tdata[81:18];
    assign in_depth = i_s_tdata[89:82];
    assign in_eval  = i_s_tdata[105:90];

    t_state             r_state, n_state;
    logic [TBL_AW-1:0]  r_clr, n_clr;
    logic [HASH_W-1:0]  r_hash, n_hash;
    logic               r_use_key, n_use_key;
    logic               r_last, n_last;
    logic               r_store, n_store;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [EVAL_W-1:0]  r_eval, n_eval;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    t_entry             r_out_entry, n_out_entry;

    logic               s_accept;
    logic               sq_ok;
    logic               kp_ok;
    logic               is_board;
    t_kind              kind;
    logic               out_free;
    logic [HASH_W-1:0]  hash_next;

    logic               key_we, key_re;
    logic [KEY_AW-1:0]  key_waddr, key_raddr;
    logic [HASH_W-1:0]  key_rdata;
    logic               tbl_we, tbl_re;
    logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
    t_entry             tbl_wdata, tbl_rdata;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign kind       = kind_of(in_char);
    assign sq_ok      = int'(in_sq) < BOARD_SQUARES;
    assign kp_ok      = int'(in_kp) < PIECE_KINDS;
    assign is_board   = (i_s_tuser == OP_QUERY) || (i_s_tuser == OP_STORE);
    assign out_free   = !r_out_valid || i_m_tready;
    assign hash_next  = r_hash ^ (r_use_key ? key_rdata : '0);

    // next state and registered values
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_hash      = r_hash;
        n_use_key   = r_use_key;
        n_last      = r_last;
        n_store     = r_store;
        n_depth     = r_depth;
        n_eval      = r_eval;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_found = r_out_found;
        n_out_entry = r_out_entry;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == TBL_AW'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept && is_board) begin
                    n_use_key = kind.valid && sq_ok;
                    n_last    = i_s_tlast;
                    n_store   = (i_s_tuser == OP_STORE);
                    n_depth   = in_depth;
                    n_eval    = in_eval;
                    n_state   = S_KEY;
                end
            end
            S_KEY: begin
                n_hash  = hash_next;
                n_state = r_last ? S_TBL : S_IDLE;
            end
            S_TBL: begin
                if (r_store) begin
                    n_hash  = '0;
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = (tbl_rdata.tag == r_hash);
                    n_out_entry = (tbl_rdata.tag == r_hash) ? tbl_rdata : '0;
                    n_hash      = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb begin
        key_we    = 1'b0;
        key_waddr = KEY_AW'(int'(in_sq) * PIECE_KINDS + int'(in_kp));
        key_re    = 1'b0;
        key_raddr = KEY_AW'(int'(in_sq) * PIECE_KINDS + int'(kind.kind));
        tbl_we    = 1'b0;
        tbl_waddr = r_clr;
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = hash_next[TBL_AW-1:0];
        case (r_state)
            S_CLEAR: begin
                tbl_we = 1'b1;
            end
            S_IDLE: begin
                key_we = s_accept && (i_s_tuser == OP_KEY_LOAD) && sq_ok && kp_ok;
                key_re = s_accept && is_board;
            end
            S_KEY: begin
                tbl_re = r_last;
            end
            S_TBL: begin
                tbl_we    = r_store;
                tbl_waddr = r_hash[TBL_AW-1:0];
                tbl_wdata = '{tag: r_hash, depth: r_depth, eval: r_eval};
            end
            default: begin
                tbl_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_use_key   <= n_use_key;
        r_last      <= n_last;
        r_store     <= n_store;
        r_depth     <= n_depth;
        r_eval      <= n_eval;
        r_out_found <= n_out_found;
        r_out_entry <= n_out_entry;
    end

    ztt_ram #(
        .WIDTH (HASH_W),
        .DEPTH (KEY_WORDS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (in_kv),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    ztt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_entry.tag, r_out_entry.eval, r_out_entry.depth};
    assign o_m_tuser  = r_out_found;

endmodule

### sv/ztt_checker.sv
`include "zobrist_transposition_table_assert.svh"

module ztt_checker
    import ztt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [OP_W-1:0]      i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [0:0]           o_m_tuser
);

    logic board_xfer;

    assign board_xfer = i_s_tvalid && o_s_tready &&
                        ((i_s_tuser == OP_QUERY) || (i_s_tuser == OP_STORE));

    `ZTT_ASSERT_RESET(a_reset_quiet, !i_rst_n, !o_s_tready && !o_m_tvalid, "busy after reset")
    `ZTT_ASSERT_NEXT(a_square_busy, board_xfer, !o_s_tready, "square transfer not waited on")
    `ZTT_ASSERT_SAME(a_miss_zero, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0, "miss not zero")
    `ZTT_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata),
        "result dropped while stalled")

endmodule

bind zobrist_transposition_table ztt_checker u_ztt_checker (.*);
